/* design/tmce_pkg.sv */
package tmce_pkg;

	// cell index width: covers page bases, cursor offsets beyond the screen and repeat counts
	localparam int IDX_W = 18;
	localparam int QDEPTH = 2;

	localparam logic [3:0] CMD_SETCUR     = 4'd0;
	localparam logic [3:0] CMD_GETCUR     = 4'd1;
	localparam logic [3:0] CMD_SHAPE      = 4'd2;
	localparam logic [3:0] CMD_PAGE       = 4'd3;
	localparam logic [3:0] CMD_SCROLLUP   = 4'd4;
	localparam logic [3:0] CMD_SCROLLDOWN = 4'd5;
	localparam logic [3:0] CMD_READ       = 4'd6;
	localparam logic [3:0] CMD_WRITECA    = 4'd7;
	localparam logic [3:0] CMD_WRITEC     = 4'd8;
	localparam logic [3:0] CMD_TELETYPE   = 4'd9;

	localparam logic [1:0] CFG_COLS  = 2'd0;
	localparam logic [1:0] CFG_ROWS  = 2'd1;
	localparam logic [1:0] CFG_PAGES = 2'd2;

	localparam logic [7:0] CH_LF        = 8'h0a;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_BEL       = 8'h07;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] SHAPE_HIDE   = 8'h20;
	localparam logic [7:0] ATTR_DEFAULT = 8'h07;
	localparam logic [15:0] BLANK_CELL  = 16'h0720;

	typedef enum logic [3:0] {
		OP_SETCUR, OP_GETCUR, OP_SHAPE, OP_PAGE, OP_SCR_UP, OP_SCR_DN,
		OP_READ, OP_WRITE_CA, OP_WRITE_C, OP_TTY, OP_NONE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        go;
		logic [2:0]  pg;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [7:0]  x2;
		logic [7:0]  y2;
		logic [7:0]  lines;
		logic [7:0]  ch;
		logic [7:0]  at;
		logic [15:0] count;
	} item_t;

	typedef struct packed {
		logic [6:0] cols;
		logic [5:0] rows;
	} geom_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DISP, ST_IX0, ST_IX1, ST_RD, ST_RD_W,
		ST_WCA, ST_WC_RD, ST_WC_WR, ST_TT0, ST_TT_WR, ST_TT1, ST_TT_LA,
		ST_SS0, ST_SS1, ST_SS2, ST_CP_RD, ST_CP_WR, ST_BL, ST_RES
	} bst_t;

endpackage

/* design/tmce_queue.sv */
module tmce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tmce_pkg::item_t din,
	input  logic            pop,
	output tmce_pkg::item_t dout,
	output logic            full,
	output logic            empty
);
	import tmce_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	item_t          ent_q [QDEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= din;
	end

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

endmodule

/* design/tmce_front.sv */
module tmce_front #(
	parameter int MAX_PAGES = 8,
	parameter int MAX_COLS  = 80,
	parameter int MAX_ROWS  = 50
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [6:0]      cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [3:0]      cmd,
	input  logic [2:0]      page,
	input  logic [7:0]      col,
	input  logic [7:0]      row,
	input  logic [7:0]      right_col,
	input  logic [7:0]      bottom_row,
	input  logic [7:0]      lines,
	input  logic [7:0]      char_code,
	input  logic [7:0]      attr,
	input  logic [15:0]     count,
	input  logic            clearing,
	input  logic            q_full,
	output logic            push,
	output tmce_pkg::item_t item,
	output tmce_pkg::geom_t geom
);
	import tmce_pkg::*;

	logic [6:0] cols_q;
	logic [5:0] rows_q;
	logic [3:0] pages_q;
	logic [6:0] ecols;
	logic [5:0] erows;
	logic [3:0] epages;
	logic [7:0] rc_c, br_c;
	logic       pvalid, win_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= 7'd80;
			rows_q  <= 6'd25;
			pages_q <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLS:  cols_q  <= cfg_data;
				CFG_ROWS:  rows_q  <= cfg_data[5:0];
				CFG_PAGES: pages_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (cols_q == '0) ecols = 7'd1;
		else if ({1'b0, cols_q} > 8'(MAX_COLS)) ecols = 7'(MAX_COLS);
		else ecols = cols_q;
		if (rows_q == '0) erows = 6'd1;
		else if ({1'b0, rows_q} > 7'(MAX_ROWS)) erows = 6'(MAX_ROWS);
		else erows = rows_q;
		if (pages_q == '0) epages = 4'd1;
		else if ({1'b0, pages_q} > 5'(MAX_PAGES)) epages = 4'(MAX_PAGES);
		else epages = pages_q;
	end

	assign geom.cols = ecols;
	assign geom.rows = erows;

	assign pvalid = ({1'b0, page} < epages);
	assign rc_c   = (right_col > {1'b0, ecols - 7'd1}) ? {1'b0, ecols - 7'd1} : right_col;
	assign br_c   = (bottom_row > {2'b0, erows - 6'd1}) ? {2'b0, erows - 6'd1} : bottom_row;
	assign win_ok = (col <= rc_c) && (row <= br_c);

	assign in_ready = !q_full && !clearing;
	assign push     = in_valid && in_ready;

	always_comb begin
		item.pg    = page;
		item.col   = col;
		item.row   = row;
		item.x2    = rc_c;
		item.y2    = br_c;
		item.lines = lines;
		item.ch    = char_code;
		item.at    = attr;
		item.count = count;
		item.op    = OP_NONE;
		item.go    = 1'b0;
		case (cmd)
			CMD_SETCUR:     begin item.op = OP_SETCUR;   item.go = pvalid; end
			CMD_GETCUR:     begin item.op = OP_GETCUR;   item.go = pvalid; end
			CMD_SHAPE:      begin item.op = OP_SHAPE;    item.go = 1'b1;   end
			CMD_PAGE:       begin item.op = OP_PAGE;     item.go = pvalid; end
			CMD_SCROLLUP:   begin item.op = OP_SCR_UP;   item.go = win_ok; end
			CMD_SCROLLDOWN: begin item.op = OP_SCR_DN;   item.go = win_ok; end
			CMD_READ:       begin item.op = OP_READ;     item.go = pvalid; end
			CMD_WRITECA:    begin item.op = OP_WRITE_CA; item.go = pvalid; end
			CMD_WRITEC:     begin item.op = OP_WRITE_C;  item.go = pvalid; end
			CMD_TELETYPE:   begin item.op = OP_TTY;      item.go = pvalid; end
			default: ;
		endcase
	end

endmodule

/* design/tmce_back.sv */
module tmce_back #(
	parameter int MEM_CELLS = 32768
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	output logic            q_pop,
	input  tmce_pkg::item_t head,
	input  tmce_pkg::geom_t geom,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            ok,
	output logic [7:0]      char_out,
	output logic [7:0]      attr_out,
	output logic [7:0]      cur_col,
	output logic [7:0]      cur_row,
	output logic [4:0]      shape_start,
	output logic [4:0]      shape_end,
	output logic            bell
);
	import tmce_pkg::*;

	localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
	localparam logic [IDX_W-1:0] CELLS = IDX_W'(MEM_CELLS);

	logic [15:0] mem [MEM_CELLS];
	logic [15:0] rdata_q;
	logic        rin_q;

	bst_t st_q, st_d;
	item_t e_q;

	logic [15:0] curs_q [8];
	logic [2:0]  apage_q;
	logic [4:0]  sh_s_q, sh_e_q;
	logic [IDX_W-1:0] clr_q;

	logic [12:0] cr_q;
	logic [IDX_W-1:0] pa_q, pb_q, idx_q, base_q, m1_q, m2_q, m3_q, a1_q, a2_q, dst_q, src_q;
	logic [15:0] cnt_q;
	logic [7:0]  x1_q, y1_q, x2_q, y2_q, n_q, wid_q, xo_q, rows_q, h_q, sattr_q;
	logic        up_q, ball_q;
	logic signed [9:0] tx_q, ty_q;
	logic [7:0]  cout_q, aout_q;
	logic        bell_q;

	logic        we, re, we_g, rin_d;
	logic [IDX_W-1:0] wa, ra;
	logic [15:0] wd, rd, cur;
	logic [IDX_W-1:0] wext;
	logic [2:0]  pgsel;
	logic        printable;
	logic signed [9:0] w1s, h1s, nx, ny;
	logic        scr_up, scr_dn;

	assign rd     = rin_q ? rdata_q : 16'h0;
	assign cur    = curs_q[e_q.pg];
	assign wext   = IDX_W'(geom.cols);
	assign pgsel  = (e_q.op == OP_SCR_UP || e_q.op == OP_SCR_DN) ? apage_q : e_q.pg;
	assign printable = (e_q.ch != CH_LF) && (e_q.ch != CH_CR) &&
		(e_q.ch != CH_BS) && (e_q.ch != CH_BEL);
	assign w1s = $signed({3'b0, geom.cols}) - 10'sd1;
	assign h1s = $signed({4'b0, geom.rows}) - 10'sd1;

	// teletype wrap and page edge handling
	always_comb begin
		nx = tx_q;
		ny = ty_q;
		if (nx > w1s) begin
			nx = 10'sd0;
			ny = ny + 10'sd1;
		end
		if (nx < 10'sd0) begin
			nx = w1s;
			ny = ny - 10'sd1;
		end
		scr_up = (ny > h1s);
		scr_dn = (ny < 10'sd0);
		if (scr_up) ny = h1s;
		if (scr_dn) ny = 10'sd0;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_q == CELLS - IDX_W'(1)) st_d = ST_IDLE;
			ST_IDLE:  if (!q_empty) st_d = ST_DISP;
			ST_DISP: begin
				if (!e_q.go) st_d = ST_RES;
				else begin
					case (e_q.op)
						OP_READ, OP_WRITE_CA, OP_WRITE_C, OP_TTY, OP_SCR_UP, OP_SCR_DN:
							st_d = ST_IX0;
						default: st_d = ST_RES;
					endcase
				end
			end
			ST_IX0: st_d = ST_IX1;
			ST_IX1: begin
				case (e_q.op)
					OP_READ:     st_d = ST_RD;
					OP_WRITE_CA: st_d = ST_WCA;
					OP_WRITE_C:  st_d = ST_WC_RD;
					OP_TTY:      st_d = ST_TT0;
					default:     st_d = ST_SS0;
				endcase
			end
			ST_RD:   st_d = ST_RD_W;
			ST_RD_W: st_d = ST_RES;
			// cells beyond memory are dropped, and the index only grows
			ST_WCA:   if (cnt_q == '0 || idx_q >= CELLS) st_d = ST_RES;
			ST_WC_RD: st_d = (cnt_q == '0 || idx_q >= CELLS) ? ST_RES : ST_WC_WR;
			ST_WC_WR: st_d = ST_WC_RD;
			ST_TT0:   st_d = printable ? ST_TT_WR : ST_TT1;
			ST_TT_WR: st_d = ST_TT1;
			ST_TT1: begin
				if (scr_up) st_d = ST_TT_LA;
				else if (scr_dn) st_d = ST_SS0;
				else st_d = ST_RES;
			end
			ST_TT_LA: st_d = ST_SS0;
			ST_SS0:   st_d = ST_SS1;
			ST_SS1:   st_d = ST_SS2;
			ST_SS2:   st_d = ball_q ? ST_BL : ST_CP_RD;
			ST_CP_RD: st_d = ST_CP_WR;
			ST_CP_WR: st_d = (xo_q == wid_q && rows_q == 8'd1) ? ST_BL : ST_CP_RD;
			ST_BL:    if (xo_q == wid_q && rows_q == 8'd1) st_d = ST_RES;
			ST_RES:   if (out_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// memory port and queue control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		wa    = '0;
		ra    = '0;
		wd    = '0;
		q_pop = 1'b0;
		case (st_q)
			ST_CLEAR: begin we = 1'b1; wa = clr_q; wd = BLANK_CELL; end
			ST_IDLE:  q_pop = !q_empty;
			ST_RD:    begin re = 1'b1; ra = idx_q; end
			ST_WCA:   begin we = (cnt_q != '0); wa = idx_q; wd = {e_q.at, e_q.ch}; end
			ST_WC_RD: begin re = 1'b1; ra = idx_q; end
			ST_WC_WR: begin we = 1'b1; wa = idx_q; wd = {rd[15:8], e_q.ch}; end
			ST_TT0:   begin re = 1'b1; ra = idx_q; end
			ST_TT_WR: begin we = 1'b1; wa = idx_q; wd = {rd[15:8], e_q.ch}; end
			// last cell of the page gives the blank attribute
			ST_TT1:   begin re = 1'b1; ra = pa_q + IDX_W'(cr_q) - IDX_W'(1); end
			ST_CP_RD: begin re = 1'b1; ra = src_q + IDX_W'(xo_q); end
			ST_CP_WR: begin we = 1'b1; wa = dst_q + IDX_W'(xo_q); wd = rd; end
			ST_BL:    begin we = 1'b1; wa = dst_q + IDX_W'(xo_q); wd = {sattr_q, CH_SPACE}; end
			default: ;
		endcase
	end

	assign we_g  = we && (wa < CELLS);
	assign rin_d = re && (ra < CELLS);

	always_ff @(posedge clk) begin
		if (we_g) mem[wa[AW-1:0]] <= wd;
		rdata_q <= mem[ra[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			rin_q   <= 1'b0;
			apage_q <= '0;
			sh_s_q  <= 5'd6;
			sh_e_q  <= 5'd7;
			for (int i = 0; i < 8; i++) curs_q[i] <= '0;
		end else begin
			st_q  <= st_d;
			rin_q <= rin_d;
			case (st_q)
				ST_CLEAR: clr_q <= clr_q + IDX_W'(1);
				ST_DISP: begin
					if (e_q.go) begin
						case (e_q.op)
							OP_SETCUR: curs_q[e_q.pg] <= {e_q.row, e_q.col};
							OP_PAGE:   apage_q <= e_q.pg;
							OP_SHAPE: begin
								if (e_q.col != SHAPE_HIDE) begin
									sh_s_q <= e_q.col[4:0];
									sh_e_q <= e_q.row[4:0];
								end
							end
							default: ;
						endcase
					end
				end
				ST_TT1: curs_q[e_q.pg] <= {ny[7:0], nx[7:0]};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cr_q <= {6'b0, geom.cols} * {7'b0, geom.rows};
		case (st_q)
			ST_IDLE: if (!q_empty) e_q <= head;
			ST_DISP: begin
				cout_q <= '0;
				aout_q <= '0;
				bell_q <= 1'b0;
				cnt_q  <= e_q.count;
				tx_q   <= $signed({2'b0, cur[7:0]});
				ty_q   <= $signed({2'b0, cur[15:8]});
			end
			ST_IX0: begin
				pa_q <= IDX_W'(pgsel) * IDX_W'(cr_q);
				pb_q <= IDX_W'(cur[15:8]) * wext;
			end
			ST_IX1: begin
				idx_q   <= pa_q + pb_q + IDX_W'(cur[7:0]);
				base_q  <= pa_q;
				x1_q    <= e_q.col;
				y1_q    <= e_q.row;
				x2_q    <= e_q.x2;
				y2_q    <= e_q.y2;
				n_q     <= e_q.lines;
				up_q    <= (e_q.op == OP_SCR_UP);
				sattr_q <= e_q.at;
			end
			ST_RD_W: begin
				cout_q <= rd[7:0];
				aout_q <= rd[15:8];
			end
			ST_WCA: begin
				if (cnt_q != '0) begin
					idx_q <= idx_q + IDX_W'(1);
					cnt_q <= cnt_q - 16'd1;
				end
			end
			ST_WC_WR: begin
				idx_q <= idx_q + IDX_W'(1);
				cnt_q <= cnt_q - 16'd1;
			end
			ST_TT0: begin
				case (e_q.ch)
					CH_LF:   ty_q <= ty_q + 10'sd1;
					CH_CR:   tx_q <= 10'sd0;
					CH_BS:   tx_q <= tx_q - 10'sd1;
					CH_BEL:  bell_q <= 1'b1;
					default: tx_q <= tx_q + 10'sd1;
				endcase
			end
			ST_TT1: begin
				base_q  <= pa_q;
				x1_q    <= '0;
				y1_q    <= '0;
				x2_q    <= w1s[7:0];
				y2_q    <= h1s[7:0];
				n_q     <= 8'd1;
				up_q    <= scr_up;
				sattr_q <= ATTR_DEFAULT;
			end
			ST_TT_LA: sattr_q <= rd[15:8];
			ST_SS0: begin
				m1_q  <= IDX_W'(y1_q) * wext;
				m2_q  <= IDX_W'(y2_q) * wext;
				h_q   <= y2_q - y1_q + 8'd1;
				wid_q <= x2_q - x1_q;
			end
			ST_SS1: begin
				m3_q   <= IDX_W'(n_q) * wext;
				a1_q   <= base_q + m1_q + IDX_W'(x1_q);
				a2_q   <= base_q + m2_q + IDX_W'(x1_q);
				ball_q <= (n_q == '0) || (n_q >= h_q);
			end
			ST_SS2: begin
				xo_q <= '0;
				if (ball_q) begin
					dst_q  <= a1_q;
					rows_q <= h_q;
				end else if (up_q) begin
					dst_q  <= a1_q;
					src_q  <= a1_q + m3_q;
					rows_q <= h_q - n_q;
				end else begin
					dst_q  <= a2_q;
					src_q  <= a2_q - m3_q;
					rows_q <= h_q - n_q;
				end
			end
			ST_CP_WR: begin
				if (xo_q == wid_q) begin
					xo_q <= '0;
					if (rows_q == 8'd1) begin
						// vacated rows: below the copy going up, top of window going down
						dst_q  <= up_q ? dst_q + wext : a1_q;
						rows_q <= n_q;
					end else begin
						rows_q <= rows_q - 8'd1;
						dst_q  <= up_q ? dst_q + wext : dst_q - wext;
						src_q  <= up_q ? src_q + wext : src_q - wext;
					end
				end else begin
					xo_q <= xo_q + 8'd1;
				end
			end
			ST_BL: begin
				if (xo_q == wid_q) begin
					xo_q   <= '0;
					rows_q <= rows_q - 8'd1;
					dst_q  <= dst_q + wext;
				end else begin
					xo_q <= xo_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	assign clearing    = (st_q == ST_CLEAR);
	assign out_valid   = (st_q == ST_RES);
	assign ok          = e_q.go;
	assign char_out    = cout_q;
	assign attr_out    = aout_q;
	assign cur_col     = cur[7:0];
	assign cur_row     = cur[15:8];
	assign shape_start = sh_s_q;
	assign shape_end   = sh_e_q;
	assign bell        = bell_q;

endmodule

/* design/text_mode_console_engine.sv */
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in        in         in_valid / in_ready    cmd, page, col, row, right_col, bottom_row,
//                                             lines, char_code, attr, count
// out       out        out_valid / out_ready  ok, char_out, attr_out, cur_col, cur_row,
//                                             shape_start, shape_end, bell
//
// cursor, shape and page commands go straight to the result; a read forms the index, then reads.
// a write with attribute stores one cell per cycle; without, each cell is read, then written.
// teletype may scroll; scrolls read and then write each moved cell and write each blanked cell.
// after reset a clearing pass blanks the whole cell memory; in_ready stays low.
// a two-item queue lets the input side run ahead while a result waits on out_ready.
module text_mode_console_engine #(
	parameter int MAX_PAGES = 8,
	parameter int MAX_COLS  = 80,
	parameter int MAX_ROWS  = 50,
	parameter int MEM_CELLS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [2:0]  page,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [7:0]  right_col,
	input  logic [7:0]  bottom_row,
	input  logic [7:0]  lines,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr,
	input  logic [15:0] count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [7:0]  char_out,
	output logic [7:0]  attr_out,
	output logic [7:0]  cur_col,
	output logic [7:0]  cur_row,
	output logic [4:0]  shape_start,
	output logic [4:0]  shape_end,
	output logic        bell
);
	import tmce_pkg::*;

	item_t item, head;
	geom_t geom;
	logic  push, pop, q_full, q_empty, clearing;

	tmce_front #(
		.MAX_PAGES(MAX_PAGES),
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.page       (page),
		.col        (col),
		.row        (row),
		.right_col  (right_col),
		.bottom_row (bottom_row),
		.lines      (lines),
		.char_code  (char_code),
		.attr       (attr),
		.count      (count),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (push),
		.item       (item),
		.geom       (geom)
	);

	tmce_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tmce_back #(
		.MEM_CELLS(MEM_CELLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (pop),
		.head        (head),
		.geom        (geom),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.char_out    (char_out),
		.attr_out    (attr_out),
		.cur_col     (cur_col),
		.cur_row     (cur_row),
		.shape_start (shape_start),
		.shape_end   (shape_end),
		.bell        (bell)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready) else $error("item accepted during clearing pass");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("queue overflow");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty) else $error("queue underflow");

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !clearing) else $error("result during clearing pass");

endmodule
